@@ hw/rtl/rgb_to_hsv_pixel_macros.svh @@
// Assertion helpers for the pixel converter.
// Compile with ASSERT_OFF defined to drop every check.
`ifndef RGB_TO_HSV_PIXEL_MACROS_SVH
`define RGB_TO_HSV_PIXEL_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property while out of reset.
`define RHSV_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rgb_to_hsv_pixel: assertion failed");

// Check a property at every edge, reset included.
`define RHSV_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rgb_to_hsv_pixel: assertion failed");

`else

`define RHSV_ASSERT(lbl, clk, rstn, prop)
`define RHSV_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ hw/rtl/rhsv_pkg.sv @@
`timescale 1ns / 1ps

package rhsv_pkg;

    localparam int PIX_W     = 8;
    localparam int QUOT_W    = 8;
    localparam int HUE_REM_W = 17;
    localparam int HUE_DIV_W = 16;
    localparam int SAT_REM_W = 16;
    localparam int SAT_DIV_W = 15;
    localparam int NUM_W     = 19;

    localparam int DEG_SIXTY      = 60;
    localparam int HUE_BASE_RED   = 0;
    localparam int HUE_BASE_GREEN = 120;
    localparam int HUE_BASE_BLUE  = 240;
    localparam int FULL_TURN      = 360;
    localparam int SAT_SCALE      = 255;

    // Data handed from cell to cell: two restoring divisions in lockstep.
    typedef struct packed {
        logic [HUE_REM_W-1:0] hue_rem;
        logic [HUE_DIV_W-1:0] hue_div;
        logic [QUOT_W-1:0]    hue_quot;
        logic [SAT_REM_W-1:0] sat_rem;
        logic [SAT_DIV_W-1:0] sat_div;
        logic [QUOT_W-1:0]    sat_quot;
        logic [PIX_W-1:0]     brightness;
    } t_stage;

endpackage

@@ hw/rtl/rhsv_stream_if.sv @@
`timescale 1ns / 1ps

interface rhsv_pix_if;
    logic                       valid;
    logic                       ready;
    logic [rhsv_pkg::PIX_W-1:0] blue;
    logic [rhsv_pkg::PIX_W-1:0] green;
    logic [rhsv_pkg::PIX_W-1:0] red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface rhsv_hsv_if;
    logic                       valid;
    logic                       ready;
    logic [rhsv_pkg::PIX_W-1:0] hue;
    logic [rhsv_pkg::PIX_W-1:0] saturation;
    logic [rhsv_pkg::PIX_W-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

@@ hw/rtl/rgb_to_hsv_pixel.sv @@
`timescale 1ns / 1ps
// Pixel converter: one 8-bit blue, green, red request in on i_pix, one
// hue, saturation, brightness result out on o_hsv. Both channels move a
// request at a clock edge where valid and ready are high.
// Hue is degrees halved (0..179), saturation is floor(255*delta/max), and
// brightness is the largest channel.
// The accepting edge loads the brightness (max), both divisors and both
// numerators into the prep register; then eight division cells in turn
// each settle one quotient bit of both divisions, giving the result.
// Throughput is one pixel per clock while o_hsv.ready is high; every stage
// is its own register with a local valid and a ready that looks one stage
// ahead, so bubbles close up.
// When the receiver stalls, the last cell holds its result and the stages
// behind it fill; i_pix.ready stays high until every stage holds a pixel.
// Reset (i_rst_n low, synchronous) empties the pipeline; in-flight pixels
// are dropped and no result is valid in the cycle after reset.

`include "rgb_to_hsv_pixel_macros.svh"

module rgb_to_hsv_pixel (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhsv_pix_if.sink   i_pix,
    rhsv_hsv_if.source o_hsv
);

    localparam int STEPS = rhsv_pkg::QUOT_W;

    // stage 0 is the prep register, stages 1..STEPS are the division cells
    logic             w_valid [STEPS+1];
    logic             w_ready [STEPS+1];
    rhsv_pkg::t_stage w_data  [STEPS+1];

    rhsv_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_blue  (i_pix.blue),
        .i_green (i_pix.green),
        .i_red   (i_pix.red),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_data[0])
    );

    // the division chain: each cell advances both quotients by one bit
    for (genvar gi = 0; gi < STEPS; gi++) begin : g_cell
        rhsv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[gi]),
            .o_ready (w_ready[gi]),
            .i_data  (w_data[gi]),
            .o_valid (w_valid[gi+1]),
            .i_ready (w_ready[gi+1]),
            .o_data  (w_data[gi+1])
        );
    end

    // last cell register doubles as the output register
    assign w_ready[STEPS]   = o_hsv.ready;
    assign o_hsv.valid      = w_valid[STEPS];
    assign o_hsv.hue        = w_data[STEPS].hue_quot;
    assign o_hsv.saturation = w_data[STEPS].sat_quot;
    assign o_hsv.brightness = w_data[STEPS].brightness;

    // hue never leaves the halved-degree range
    `RHSV_ASSERT(a_hue_range, i_clk, i_rst_n, o_hsv.valid |-> o_hsv.hue <= 8'd179)
    // a nonzero saturation needs a nonzero brightness
    `RHSV_ASSERT(a_sat_bright, i_clk, i_rst_n,
        (o_hsv.valid && o_hsv.saturation != '0) |-> o_hsv.brightness != '0)
    // a colored hue implies a nonzero saturation
    `RHSV_ASSERT(a_hue_sat, i_clk, i_rst_n,
        (o_hsv.valid && o_hsv.hue != '0) |-> o_hsv.saturation != '0)
    // reset empties the chain
    `RHSV_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_hsv.valid)

endmodule

@@ hw/rtl/rhsv_prep.sv @@
`timescale 1ns / 1ps

module rhsv_prep (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rhsv_pkg::PIX_W-1:0] i_blue,
    input  logic [rhsv_pkg::PIX_W-1:0] i_green,
    input  logic [rhsv_pkg::PIX_W-1:0] i_red,
    output logic                       o_valid,
    input  logic                       i_ready,
    output rhsv_pkg::t_stage           o_data
);

    localparam int PW = rhsv_pkg::PIX_W;
    localparam int NW = rhsv_pkg::NUM_W;
    localparam logic signed [NW-1:0] SIXTY = NW'(rhsv_pkg::DEG_SIXTY);

    logic                    r_valid;
    rhsv_pkg::t_stage        r_data;
    rhsv_pkg::t_stage        n_data;

    logic [PW-1:0]           w_max;
    logic [PW-1:0]           w_min;
    logic [PW-1:0]           w_delta;
    logic [PW-1:0]           w_delta_eff;
    logic [PW-1:0]           w_max_eff;
    logic [NW-1:0]           w_base;
    logic signed [PW+1:0]    w_diff;
    logic signed [NW-1:0]    w_num;
    logic signed [NW-1:0]    w_wrap;

    always_comb begin
        w_max = i_red;
        if (i_green > w_max) begin
            w_max = i_green;
        end
        if (i_blue > w_max) begin
            w_max = i_blue;
        end
        w_min = i_red;
        if (i_green < w_min) begin
            w_min = i_green;
        end
        if (i_blue < w_min) begin
            w_min = i_blue;
        end
        w_delta = w_max - w_min;

        // sector priority: red, then green, then blue
        if (i_red == w_max) begin
            w_base = NW'(rhsv_pkg::HUE_BASE_RED);
            w_diff = $signed({2'b00, i_green}) - $signed({2'b00, i_blue});
        end else if (i_green == w_max) begin
            w_base = NW'(rhsv_pkg::HUE_BASE_GREEN);
            w_diff = $signed({2'b00, i_blue}) - $signed({2'b00, i_red});
        end else begin
            w_base = NW'(rhsv_pkg::HUE_BASE_BLUE);
            w_diff = $signed({2'b00, i_red}) - $signed({2'b00, i_green});
        end

        w_num  = $signed(w_base * NW'(w_delta)) + NW'(w_diff) * SIXTY;
        w_wrap = w_num;
        if (w_num < 0) begin
            w_wrap = w_num + $signed(NW'(rhsv_pkg::FULL_TURN) * NW'(w_delta));
        end

        // a zero divisor would fill the quotient with ones; numerators are zero there
        w_delta_eff = (w_delta == '0) ? PW'(1) : w_delta;
        w_max_eff   = (w_max == '0) ? PW'(1) : w_max;

        n_data.hue_rem    = (w_delta == '0) ? '0 : rhsv_pkg::HUE_REM_W'(w_wrap);
        n_data.hue_div    = {w_delta_eff, 8'b0};
        n_data.hue_quot   = '0;
        n_data.sat_rem    = rhsv_pkg::SAT_REM_W'(rhsv_pkg::SAT_SCALE)
                          * rhsv_pkg::SAT_REM_W'(w_delta);
        n_data.sat_div    = {w_max_eff, 7'b0};
        n_data.sat_quot   = '0;
        n_data.brightness = w_max;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

@@ hw/rtl/rhsv_div_cell.sv @@
`timescale 1ns / 1ps

module rhsv_div_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rhsv_pkg::t_stage i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output rhsv_pkg::t_stage o_data
);

    logic             r_valid;
    rhsv_pkg::t_stage r_data;
    rhsv_pkg::t_stage n_data;
    logic             w_hue_take;
    logic             w_sat_take;

    // one quotient bit per cell for each lane; shift the divisors down for the next cell
    always_comb begin
        n_data     = i_data;
        w_hue_take = {1'b0, i_data.hue_div} <= i_data.hue_rem;
        w_sat_take = {1'b0, i_data.sat_div} <= i_data.sat_rem;
        if (w_hue_take) begin
            n_data.hue_rem = i_data.hue_rem - {1'b0, i_data.hue_div};
        end
        if (w_sat_take) begin
            n_data.sat_rem = i_data.sat_rem - {1'b0, i_data.sat_div};
        end
        n_data.hue_quot = {i_data.hue_quot[rhsv_pkg::QUOT_W-2:0], w_hue_take};
        n_data.sat_quot = {i_data.sat_quot[rhsv_pkg::QUOT_W-2:0], w_sat_take};
        n_data.hue_div  = i_data.hue_div >> 1;
        n_data.sat_div  = i_data.sat_div >> 1;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
